[design/compass_attitude_smoother_unit_defines.svh]
// Assertion macros shared by the compass attitude smoother.
`ifndef COMPASS_ATTITUDE_SMOOTHER_UNIT_DEFINES_SVH
`define COMPASS_ATTITUDE_SMOOTHER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CAS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/cas_pkg.sv]
`default_nettype none

package cas_pkg;

   // Item kinds on the request channel.
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_LEVEL  = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_MOUNT_OFFSET    = 1'b0;
   localparam logic CSR_SMOOTHING_ALPHA = 1'b1;

   // Reset value of the smoothing factor (0.25 with 16 fraction bits).
   localparam logic [15:0] ALPHA_RESET = 16'd16384;

   // Full circle in hundredths of a degree and its multiples for the input wrap.
   localparam logic [16:0] CIRCLE_1X = 17'd36000;
   localparam logic [16:0] CIRCLE_2X = 17'd72000;
   localparam logic [16:0] CIRCLE_3X = 17'd108000;

   // Full and half circle with 16 fraction bits.
   localparam logic [31:0]        CIRCLE_FX_U = 32'd2359296000;
   localparam logic signed [33:0] CIRCLE_FX   = 34'sd2359296000;
   localparam logic signed [33:0] HALF_FX     = 34'sd1179648000;

   // Offset saturation bound.
   localparam logic signed [16:0] OFFSET_MAX = 17'sd32767;

endpackage

`default_nettype wire

[design/compass_attitude_smoother_unit.sv]
// Compass attitude smoother: a sample item wraps raw heading plus the mount
// offset into 0..35999, moves the smoothed heading along the shortest arc by
// alpha times the wrapped difference, levels pitch and roll by stored offsets
// and updates their running minimum and maximum; a level item (ignored until a
// first sample) captures the negated last raw pitch and roll as offsets and
// clears the extremes. Every item gives exactly one response item. The block
// takes one item per clock while the response channel is not stalled, through
// an input register (which already holds the wrapped heading) and a response
// register, with the single 17x32 alpha multiply and the state update between
// them. The state feeds back within that one stage, so back-to-back items see
// each other's updates. Configuration writes are always accepted and must only
// be issued while the block is idle.
`default_nettype none

`include "compass_attitude_smoother_unit_defines.svh"

module compass_attitude_smoother_unit (
   input  wire                clock,
   input  wire                reset,
   // Configuration port.
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire                csr_index,
   input  wire         [15:0] csr_data,
   // Request channel.
   input  wire                req_valid,
   output logic               req_ready,
   input  wire                req_type,
   input  wire         [15:0] req_raw_heading,
   input  wire  signed [15:0] req_raw_pitch,
   input  wire  signed [15:0] req_raw_roll,
   // Response channel.
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic        [15:0] rsp_compass_heading,
   output logic signed [16:0] rsp_pitch_level_out,
   output logic signed [16:0] rsp_roll_level_out,
   output logic signed [16:0] rsp_pitch_max,
   output logic signed [16:0] rsp_pitch_min,
   output logic signed [16:0] rsp_roll_max,
   output logic signed [16:0] rsp_roll_min,
   output logic               rsp_extremes_valid,
   output logic               rsp_heading_valid
);

   // Configuration registers.
   logic [15:0] mount_offset_ff;
   logic [15:0] alpha_ff;

   // Input stage.
   logic               in_valid_ff;
   logic               in_type_ff;
   logic        [15:0] in_heading_ff;
   logic signed [15:0] in_pitch_ff;
   logic signed [15:0] in_roll_ff;

   // Block state and next values.
   logic        [31:0] smooth_ff, smooth_in;
   logic               heading_seen_ff, heading_seen_in;
   logic signed [15:0] pitch_offset_ff, pitch_offset_in;
   logic signed [15:0] roll_offset_ff, roll_offset_in;
   logic signed [15:0] last_pitch_ff, last_pitch_in;
   logic signed [15:0] last_roll_ff, last_roll_in;
   logic               raw_seen_ff, raw_seen_in;
   logic signed [16:0] pitch_max_ff, pitch_max_in;
   logic signed [16:0] pitch_min_ff, pitch_min_in;
   logic signed [16:0] roll_max_ff, roll_max_in;
   logic signed [16:0] roll_min_ff, roll_min_in;
   logic               extremes_seen_ff, extremes_seen_in;

   // Output stage.
   logic out_valid_ff;

   // Handshake.
   logic advance;
   logic in_take;
   logic stage_fire;

   assign csr_ready  = 1'b1;
   assign advance    = !out_valid_ff || rsp_ready;
   assign req_ready  = !in_valid_ff || advance;
   assign in_take    = req_valid && req_ready;
   assign stage_fire = in_valid_ff && advance;
   assign rsp_valid  = out_valid_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         mount_offset_ff <= '0;
         alpha_ff        <= cas_pkg::ALPHA_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            cas_pkg::CSR_MOUNT_OFFSET:    mount_offset_ff <= csr_data;
            cas_pkg::CSR_SMOOTHING_ALPHA: alpha_ff        <= csr_data;
            default: ;
         endcase
      end
   end

   // Heading plus mount offset, reduced modulo a full circle on the way in.
   logic [16:0] head_sum;
   logic [16:0] head_wrap;

   always_comb begin
      head_sum = {1'b0, req_raw_heading} + {1'b0, mount_offset_ff};
      if (head_sum >= cas_pkg::CIRCLE_3X) begin
         head_wrap = head_sum - cas_pkg::CIRCLE_3X;
      end else if (head_sum >= cas_pkg::CIRCLE_2X) begin
         head_wrap = head_sum - cas_pkg::CIRCLE_2X;
      end else if (head_sum >= cas_pkg::CIRCLE_1X) begin
         head_wrap = head_sum - cas_pkg::CIRCLE_1X;
      end else begin
         head_wrap = head_sum;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_type_ff    <= req_type;
         in_heading_ff <= head_wrap[15:0];
         in_pitch_ff   <= req_raw_pitch;
         in_roll_ff    <= req_raw_roll;
      end
   end

   // Shortest-arc smoothing step.
   logic        [31:0] target;
   logic signed [33:0] diff;
   logic signed [33:0] diff_wrap;
   logic signed [48:0] product;
   logic signed [32:0] step;
   logic signed [33:0] smooth_sum;
   logic        [31:0] smooth_step;

   always_comb begin
      target = {in_heading_ff, 16'd0};
      diff   = $signed({2'b00, target}) - $signed({2'b00, smooth_ff});
      if (diff > cas_pkg::HALF_FX) begin
         diff_wrap = diff - cas_pkg::CIRCLE_FX;
      end else if (diff < -cas_pkg::HALF_FX) begin
         diff_wrap = diff + cas_pkg::CIRCLE_FX;
      end else begin
         diff_wrap = diff;
      end
      // The upper bits of the product are the step rounded toward minus infinity.
      product    = $signed({1'b0, alpha_ff}) * $signed(diff_wrap[31:0]);
      step       = product[48:16];
      smooth_sum = $signed({2'b00, smooth_ff}) + $signed({step[32], step});
      if (smooth_sum >= cas_pkg::CIRCLE_FX) begin
         smooth_step = 32'(smooth_sum - cas_pkg::CIRCLE_FX);
      end else if (smooth_sum < 34'sd0) begin
         smooth_step = 32'(smooth_sum + cas_pkg::CIRCLE_FX);
      end else begin
         smooth_step = smooth_sum[31:0];
      end
   end

   // Leveled attitude of a sample and the captured offsets of a level item.
   logic signed [16:0] pitch_lvl;
   logic signed [16:0] roll_lvl;
   logic signed [16:0] pitch_neg;
   logic signed [16:0] roll_neg;

   always_comb begin
      pitch_lvl = 17'(in_pitch_ff) + 17'(pitch_offset_ff);
      roll_lvl  = 17'(in_roll_ff) + 17'(roll_offset_ff);
      pitch_neg = -17'(last_pitch_ff);
      roll_neg  = -17'(last_roll_ff);
   end

   // Next state.
   always_comb begin
      smooth_in        = smooth_ff;
      heading_seen_in  = heading_seen_ff;
      pitch_offset_in  = pitch_offset_ff;
      roll_offset_in   = roll_offset_ff;
      last_pitch_in    = last_pitch_ff;
      last_roll_in     = last_roll_ff;
      raw_seen_in      = raw_seen_ff;
      pitch_max_in     = pitch_max_ff;
      pitch_min_in     = pitch_min_ff;
      roll_max_in      = roll_max_ff;
      roll_min_in      = roll_min_ff;
      extremes_seen_in = extremes_seen_ff;
      if (in_type_ff == cas_pkg::REQ_SAMPLE) begin
         smooth_in        = heading_seen_ff ? smooth_step : target;
         heading_seen_in  = 1'b1;
         last_pitch_in    = in_pitch_ff;
         last_roll_in     = in_roll_ff;
         raw_seen_in      = 1'b1;
         extremes_seen_in = 1'b1;
         if (!extremes_seen_ff || pitch_lvl > pitch_max_ff) pitch_max_in = pitch_lvl;
         if (!extremes_seen_ff || pitch_lvl < pitch_min_ff) pitch_min_in = pitch_lvl;
         if (!extremes_seen_ff || roll_lvl > roll_max_ff) roll_max_in = roll_lvl;
         if (!extremes_seen_ff || roll_lvl < roll_min_ff) roll_min_in = roll_lvl;
      end else if (raw_seen_ff) begin
         // Negation saturates only for a raw value of -32768.
         pitch_offset_in  = (pitch_neg > cas_pkg::OFFSET_MAX) ? 16'sd32767
                                                              : pitch_neg[15:0];
         roll_offset_in   = (roll_neg > cas_pkg::OFFSET_MAX) ? 16'sd32767
                                                             : roll_neg[15:0];
         pitch_max_in     = '0;
         pitch_min_in     = '0;
         roll_max_in      = '0;
         roll_min_in      = '0;
         extremes_seen_in = 1'b0;
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff        <= '0;
         heading_seen_ff  <= 1'b0;
         pitch_offset_ff  <= '0;
         roll_offset_ff   <= '0;
         last_pitch_ff    <= '0;
         last_roll_ff     <= '0;
         raw_seen_ff      <= 1'b0;
         pitch_max_ff     <= '0;
         pitch_min_ff     <= '0;
         roll_max_ff      <= '0;
         roll_min_ff      <= '0;
         extremes_seen_ff <= 1'b0;
      end else if (stage_fire) begin
         smooth_ff        <= smooth_in;
         heading_seen_ff  <= heading_seen_in;
         pitch_offset_ff  <= pitch_offset_in;
         roll_offset_ff   <= roll_offset_in;
         last_pitch_ff    <= last_pitch_in;
         last_roll_ff     <= last_roll_in;
         raw_seen_ff      <= raw_seen_in;
         pitch_max_ff     <= pitch_max_in;
         pitch_min_ff     <= pitch_min_in;
         roll_max_ff      <= roll_max_in;
         roll_min_ff      <= roll_min_in;
         extremes_seen_ff <= extremes_seen_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_fire) begin
         rsp_compass_heading <= smooth_in[31:16];
         rsp_pitch_level_out <= 17'(last_pitch_in) + 17'(pitch_offset_in);
         rsp_roll_level_out  <= 17'(last_roll_in) + 17'(roll_offset_in);
         rsp_pitch_max       <= extremes_seen_in ? pitch_max_in : '0;
         rsp_pitch_min       <= extremes_seen_in ? pitch_min_in : '0;
         rsp_roll_max        <= extremes_seen_in ? roll_max_in : '0;
         rsp_roll_min        <= extremes_seen_in ? roll_min_in : '0;
         rsp_extremes_valid  <= extremes_seen_in;
         rsp_heading_valid   <= heading_seen_in;
      end
   end

   // Checks on the internal state.
   `CAS_ASSERT_NOW(a_heading_range, clock, reset, 1'b1, smooth_ff < cas_pkg::CIRCLE_FX_U, "smoothed heading left the circle")
   `CAS_ASSERT_NOW(a_extremes_order, clock, reset, extremes_seen_ff, (pitch_min_ff <= pitch_max_ff) && (roll_min_ff <= roll_max_ff), "minimum above maximum")
   `CAS_ASSERT_NEXT(a_level_ignored, clock, reset, stage_fire && (in_type_ff == cas_pkg::REQ_LEVEL) && !raw_seen_ff, $stable(pitch_offset_ff) && $stable(roll_offset_ff), "level item before any sample changed the offsets")

endmodule

`default_nettype wire
